// ===== rtl/sdf_pkg.sv =====
// Shared types and constants for the signed decimal field formatter.
`timescale 1ns / 1ps
package sdf_pkg;
	localparam logic [7:0] CH_ZERO  = 8'd48;
	localparam logic [7:0] CH_SPACE = 8'd32;
	localparam logic [7:0] CH_PLUS  = 8'd43;
	localparam logic [7:0] CH_MINUS = 8'd45;
	localparam int NDIG = 10;

	// One decimal step: quotient and remainder of a value by ten.
	typedef struct packed {
		logic [31:0] quo;
		logic [3:0]  rem;
	} div10_t;

	function automatic div10_t div10(input logic [31:0] v);
		logic [65:0] p;
		logic [31:0] q;
		logic [31:0] r;
		div10_t      d;
		p = {34'd0, v} * 66'h0CCCCCCCD;
		q = {1'b0, p[65:35]};
		r = v - q * 32'd10;
		d.quo = q;
		d.rem = r[3:0];
		return d;
	endfunction
endpackage

// ===== rtl/sdf_digits.sv =====
// Digit extraction pipeline: one decimal digit per stage.
`timescale 1ns / 1ps
module sdf_digits import sdf_pkg::*; #(
	parameter int SIDE_W = 1
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [31:0]       mag,
	input  logic [SIDE_W-1:0] side_in,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [4*NDIG-1:0] digs,
	output logic [3:0]        ndig,
	output logic [SIDE_W-1:0] side_out
);
	logic              v_s [1:NDIG];
	logic [31:0]       m_s [1:NDIG];
	logic [4*NDIG-1:0] d_s [1:NDIG];
	logic [3:0]        n_s [1:NDIG];
	logic [SIDE_W-1:0] x_s [1:NDIG];
	logic              adv [NDIG+1];

	assign adv[NDIG] = out_ready || !v_s[NDIG];
	assign in_ready = adv[0];

	genvar g;
	generate
		for (g = 0; g < NDIG; g++) begin : g_st
			logic              vi;
			logic [31:0]       mi;
			logic [4*NDIG-1:0] di;
			logic [3:0]        ni;
			logic [SIDE_W-1:0] xi;
			div10_t            dv;
			// stage input: the item ports or the previous stage
			if (g == 0) begin : g_first
				assign vi = in_valid;
				assign mi = mag;
				assign di = '0;
				assign ni = '0;
				assign xi = side_in;
			end else begin : g_next
				assign vi = v_s[g];
				assign mi = m_s[g];
				assign di = d_s[g];
				assign ni = n_s[g];
				assign xi = x_s[g];
			end
			assign dv = div10(mi);
			assign adv[g] = adv[g+1] || !v_s[g+1];
			// one digit per stage, least significant first
			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					v_s[g+1] <= 1'b0;
				end else if (adv[g]) begin
					v_s[g+1] <= vi;
				end
			end
			always_ff @(posedge clk) begin
				if (adv[g]) begin
					m_s[g+1] <= dv.quo;
					d_s[g+1] <= di | ({{(4*NDIG-4){1'b0}}, dv.rem} << (4*g));
					n_s[g+1] <= (mi != 32'd0) ? 4'(g + 1) : ni;
					x_s[g+1] <= xi;
				end
			end
		end
	endgenerate

	assign out_valid = v_s[NDIG];
	assign digs      = d_s[NDIG];
	assign ndig      = n_s[NDIG];
	assign side_out  = x_s[NDIG];
endmodule

// ===== rtl/signed_decimal_field_formatter.sv =====
// Top level: signed decimal field formatter, printf-style %d text.
`timescale 1ns / 1ps
// Each accepted item is turned into its %d text, one ASCII character per
// output transfer, last marking the final one; an empty field gives none.
// The value passes a ten-stage digit pipeline (one divide-by-ten per
// stage); the serializer then emits one character a cycle while
// out_ready is high. While one item is serialized, following items fill
// the digit pipeline behind it.
module signed_decimal_field_formatter import sdf_pkg::*; #(
	parameter int MAX_FIELD = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [31:0] value,
	input  logic [6:0]  field_width,
	input  logic [5:0]  min_digits,
	input  logic [4:0]  format_flags,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  out_char,
	output logic        last
);
	localparam int CW = $clog2(MAX_FIELD + 1);

	typedef struct packed {
		logic [6:0] wid;
		logic [5:0] prec;
		logic [4:0] flags;
		logic       neg;
		logic       zero;
	} side_t;

	side_t       side_in, side_o;
	logic [31:0] mag;
	logic        dv;
	logic        dready;
	logic [4*NDIG-1:0] digs;
	logic [3:0]  ndig_raw;

	assign mag = value[31] ? (32'd0 - value) : value;
	assign side_in = '{wid: field_width, prec: min_digits, flags: format_flags,
		neg: value[31], zero: (value == 32'd0)};

	sdf_digits #(.SIDE_W($bits(side_t))) u_dig (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
		.mag(mag), .side_in(side_in), .out_valid(dv), .out_ready(dready),
		.digs(digs), .ndig(ndig_raw), .side_out(side_o)
	);

	// Layout of the field from the digit stage output
	logic        left, plus_f, space_f, zpad, given, sgn, zmode;
	logic [CW:0] wid_c, prec_c, nd, dl, body, w;
	always_comb begin
		left    = side_o.flags[0];
		plus_f  = side_o.flags[1];
		space_f = side_o.flags[2];
		zpad    = side_o.flags[3];
		given   = side_o.flags[4];
		wid_c   = (CW+1)'(side_o.wid);
		if (wid_c > (CW+1)'(MAX_FIELD)) wid_c = (CW+1)'(MAX_FIELD);
		prec_c  = given ? (CW+1)'(side_o.prec) : '0;
		if (prec_c > (CW+1)'(MAX_FIELD - 1)) prec_c = (CW+1)'(MAX_FIELD - 1);
		if (side_o.zero) nd = (given && prec_c == '0) ? '0 : (CW+1)'(1);
		else nd = (CW+1)'(ndig_raw);
		dl   = (prec_c > nd) ? prec_c : nd;
		sgn  = side_o.neg || plus_f || space_f;
		body = dl + (CW+1)'(sgn);
		w    = (wid_c > body) ? wid_c : body;
		zmode = !left && zpad && !given && (body != '0);
	end

	// Serializer registers
	logic              busy_q;
	logic [CW:0]       pos_q, w_q, sstart_q, dstart_q, nd_q;
	logic              sgn_q, zmode_q;
	logic [7:0]        signc_q;
	logic [4*NDIG-1:0] digs_q;
	logic              fin;

	assign fin    = busy_q && out_ready && (pos_q + 1'b1 == w_q);
	assign dready = !busy_q || fin;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			pos_q  <= '0;
		end else if (dready) begin
			busy_q <= dv && (w != '0);
			pos_q  <= '0;
		end else if (out_ready) begin
			pos_q <= pos_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (dready && dv) begin
			w_q     <= w;
			nd_q    <= nd;
			sgn_q   <= sgn;
			zmode_q <= zmode;
			digs_q  <= digs;
			signc_q <= side_o.neg ? CH_MINUS : (plus_f ? CH_PLUS : CH_SPACE);
			// sign position and first digit position
			if (left || zmode) sstart_q <= '0;
			else sstart_q <= w - body;
			dstart_q <= w - nd - (left ? (w - body) : '0);
		end
	end

	// Character select at the current position
	logic [CW:0] di;
	logic [3:0]  dig;
	always_comb begin
		di  = dstart_q + nd_q - 1'b1 - pos_q;
		dig = digs_q[4*di[3:0] +: 4];
		if (sgn_q && pos_q == sstart_q) out_char = signc_q;
		else if (pos_q >= dstart_q && pos_q < dstart_q + nd_q) out_char = CH_ZERO + 8'(dig);
		else if (pos_q < sstart_q) out_char = zmode_q ? CH_ZERO : CH_SPACE;
		else if (pos_q < dstart_q) out_char = CH_ZERO;
		else out_char = CH_SPACE;
	end

	assign out_valid = busy_q;
	assign last      = (pos_q + 1'b1 == w_q);

	a_pos_in_field: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> pos_q < w_q) else $error("position past field end");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q && !out_ready |=> busy_q && $stable(pos_q))
		else $error("stalled character moved");
	a_fin: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && last |-> dready) else $error("finish not released");
endmodule

// ===== tb/testbench.sv =====
// Testbench for the signed decimal field formatter: directed and random %d fields.
`timescale 1ns / 1ps
module testbench import sdf_pkg::*;;

	localparam int MAX_FIELD = 64;
	localparam logic [4:0] FL_LEFT  = 5'd1;
	localparam logic [4:0] FL_PLUS  = 5'd2;
	localparam logic [4:0] FL_SPACE = 5'd4;
	localparam logic [4:0] FL_ZERO  = 5'd8;
	localparam logic [4:0] FL_PREC  = 5'd16;

	typedef struct packed {
		logic [7:0] ch;
		logic       fin;
	} field_char_t;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic [31:0] value;
	logic [6:0]  field_width;
	logic [5:0]  min_digits;
	logic [4:0]  format_flags;
	logic        out_valid;
	logic        out_ready;
	logic [7:0]  out_char;
	logic        last;

	field_char_t pending_chars[$];
	int          n_fail;
	int          n_items;
	int          n_chars;
	int          n_empty;
	bit          idle_enable;

	signed_decimal_field_formatter #(.MAX_FIELD(MAX_FIELD)) DUT (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.value(value), .field_width(field_width),
		.min_digits(min_digits), .format_flags(format_flags),
		.out_valid(out_valid), .out_ready(out_ready),
		.out_char(out_char), .last(last)
	);

	// Clock and reset
	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		arst_n = 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
	end

	// Build the expected %d text of one item and queue its characters.
	task automatic format_field(input logic [31:0] v, input logic [6:0] wid_in,
			input logic [5:0] prec_in, input logic [4:0] fl);
		logic [7:0]  digs[12];
		logic [7:0]  txt[$];
		logic [31:0] mag;
		logic [7:0]  sc;
		int          nd, prec, wid, dl, sgn, body, w, k;
		bit          neg, given;
		neg   = v[31];
		given = (fl & FL_PREC) != 0;
		prec  = given ? int'(prec_in) : 0;
		wid   = int'(wid_in);
		nd    = 0;
		if (wid > MAX_FIELD) wid = MAX_FIELD;
		if (prec > MAX_FIELD - 1) prec = MAX_FIELD - 1;
		mag = neg ? (32'd0 - v) : v;
		if (mag == 0) begin
			if (!(given && prec == 0)) begin
				digs[0] = CH_ZERO;
				nd = 1;
			end
		end else begin
			while (mag != 0) begin
				digs[nd] = CH_ZERO + 8'(mag % 10);
				mag = mag / 10;
				nd++;
			end
		end
		dl  = (prec > nd) ? prec : nd;
		sgn = (neg || (fl & (FL_PLUS | FL_SPACE)) != 0) ? 1 : 0;
		sc  = neg ? CH_MINUS : ((fl & FL_PLUS) != 0) ? CH_PLUS : CH_SPACE;
		body = dl + sgn;
		w = (wid > body) ? wid : body;
		if ((fl & FL_LEFT) != 0) begin
			if (sgn != 0) txt.push_back(sc);
			for (k = nd; k < dl; k++) txt.push_back(CH_ZERO);
			for (k = nd; k > 0; k--) txt.push_back(digs[k - 1]);
			while (txt.size() < w) txt.push_back(CH_SPACE);
		end else if ((fl & FL_ZERO) != 0 && !given && body > 0) begin
			if (sgn != 0) txt.push_back(sc);
			while (txt.size() < w - nd) txt.push_back(CH_ZERO);
			for (k = nd; k > 0; k--) txt.push_back(digs[k - 1]);
		end else begin
			while (txt.size() < w - body) txt.push_back(CH_SPACE);
			if (sgn != 0) txt.push_back(sc);
			for (k = nd; k < dl; k++) txt.push_back(CH_ZERO);
			for (k = nd; k > 0; k--) txt.push_back(digs[k - 1]);
		end
		if (w == 0) n_empty++;
		for (k = 0; k < w; k++) pending_chars.push_back({txt[k], k == w - 1});
	endtask

	// Send one item; valid is held until the transfer.
	task automatic send_item(input logic [31:0] v, input logic [6:0] w,
			input logic [5:0] p, input logic [4:0] fl);
		while (idle_enable && $urandom_range(99) < 28) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid     <= 1'b1;
		value        <= v;
		field_width  <= w;
		min_digits   <= p;
		format_flags <= fl;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		format_field(v, w, p, fl);
		n_items++;
	endtask

	// Receiver: random stalls, check each character transfer.
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (pending_chars.size() == 0) begin
					$error("unexpected char: out_char %0h last %0b", out_char, last);
					n_fail++;
				end else begin
					field_char_t e;
					e = pending_chars.pop_front();
					if (out_char !== e.ch) begin
						$error("out_char: expected %0h actual %0h", e.ch, out_char);
						n_fail++;
					end
					if (last !== e.fin) begin
						$error("last: expected %0b actual %0b", e.fin, last);
						n_fail++;
					end
					n_chars++;
				end
			end
			out_ready <= idle_enable ? ($urandom_range(99) >= 28) : 1'b1;
		end
	end

	task automatic wait_drained();
		in_valid <= 1'b0;
		while (pending_chars.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	// Directed: extremes, every flag, zero with zero precision, clamping
	task automatic test_directed();
		send_item(32'd0, 7'd0, 6'd0, 5'd0);
		send_item(32'd0, 7'd0, 6'd0, FL_PREC);
		send_item(32'd0, 7'd5, 6'd0, FL_PREC | FL_PLUS);
		send_item(32'd0, 7'd3, 6'd0, FL_PREC | FL_LEFT | FL_SPACE);
		send_item(32'h8000_0000, 7'd0, 6'd0, 5'd0);
		send_item(32'h8000_0000, 7'd20, 6'd0, FL_ZERO);
		send_item(32'h7FFF_FFFF, 7'd15, 6'd12, FL_PREC | FL_PLUS);
		send_item(32'hFFFF_FFFF, 7'd6, 6'd0, FL_LEFT);
		send_item(32'd42, 7'd8, 6'd0, FL_ZERO | FL_PLUS);
		send_item(32'd42, 7'd8, 6'd0, FL_ZERO | FL_LEFT);
		send_item(32'd42, 7'd8, 6'd4, FL_ZERO | FL_PREC);
		send_item(32'd7, 7'd4, 6'd0, FL_SPACE | FL_PLUS);
		send_item(32'd7, 7'd4, 6'd0, FL_SPACE);
		send_item(32'd1, 7'd127, 6'd0, 5'd0);
		send_item(32'd1, 7'd64, 6'd0, FL_ZERO);
		send_item(32'hFFFF_FF9C, 7'd0, 6'd63, FL_PREC);
		send_item(32'd5, 7'd100, 6'd63, FL_PREC | FL_LEFT | FL_PLUS);
		send_item(32'd0, 7'd10, 6'd0, FL_ZERO | FL_SPACE);
		send_item(32'd123456789, 7'd3, 6'd0, 5'd31);
		send_item(32'd0, 7'd0, 6'd0, FL_ZERO);
		send_item(32'd0, 7'd0, 6'd0, FL_PREC | FL_ZERO);
	endtask

	function automatic logic [31:0] pick_value();
		case ($urandom_range(4))
			0: return $urandom_range(9);
			1: return 32'd0 - $urandom_range(1000);
			2: return {$urandom_range(1) ? 32'h8000_0000 : 32'h7FFF_FFFF};
			default: return $urandom;
		endcase
	endfunction

	// Random: mostly short fields, a few at the limit
	task automatic test_random(input int count);
		logic [6:0] w;
		logic [5:0] p;
		for (int i = 0; i < count; i++) begin
			w = ($urandom_range(9) == 0) ? 7'($urandom) : 7'($urandom_range(16));
			p = ($urandom_range(9) == 0) ? 6'($urandom) : 6'($urandom_range(12));
			send_item(pick_value(), w, p, 5'($urandom));
		end
	endtask

	// Hold the sender until every expected character has arrived.
	task automatic test_drain_pause();
		wait_drained();
		send_item(32'hFFFF_FFF6, 7'd4, 6'd2, FL_PREC);
		wait_drained();
	endtask

	// Safety limit
	initial begin
		#5ms;
		$display("status: fail");
		$finish;
	end

	initial begin
		in_valid     <= 1'b0;
		value        <= '0;
		field_width  <= '0;
		min_digits   <= '0;
		format_flags <= '0;
		out_ready    <= 1'b0;
		n_fail = 0;
		n_items = 0;
		n_chars = 0;
		n_empty = 0;
		idle_enable = 1'b1;
		@(posedge arst_n);
		@(posedge clk);
		test_directed();
		test_random(120);
		test_drain_pause();
		idle_enable = 1'b0;
		test_random(40);
		idle_enable = 1'b1;
		test_random(80);
		wait_drained();
		$display("covered %0d items, %0d characters, %0d empty fields",
			n_items, n_chars, n_empty);
		$display("directed flag and limit cases, random values with and without idling");
		if (n_fail == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end
endmodule

// ===== files.f =====
rtl/sdf_pkg.sv
rtl/sdf_digits.sv
rtl/signed_decimal_field_formatter.sv
tb/testbench.sv
